/* hdl/radius_gated_position_smoother_unit_defines.svh */
// assertion macros used by the checker of the smoother
`ifndef RADIUS_GATED_POSITION_SMOOTHER_UNIT_DEFINES_SVH
`define RADIUS_GATED_POSITION_SMOOTHER_UNIT_DEFINES_SVH

// consequent checked in the cycle after the antecedent
`define RGPS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgps check failed");

// consequent starts in the cycle of the antecedent
`define RGPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error("rgps check failed");

`endif

/* hdl/rgps_pkg.sv */
// shared constants of the radius gated position smoother
package rgps_pkg;

  // ring of stored points
  localparam int RING_DEPTH = 512;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);

  // word fields
  localparam int POS_W      = 16;
  localparam int ENTRY_W    = 2 * POS_W;

  // configuration registers
  localparam int RADIUS_W   = 16;
  localparam int HLEN_W     = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GATE_RADIUS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LEN = CFG_IDX_W'(1);

  localparam logic [RADIUS_W-1:0] GATE_RADIUS_RST = RADIUS_W'(1000);
  localparam logic [HLEN_W-1:0]   HISTORY_LEN_RST = HLEN_W'(500);

endpackage

/* hdl/rgps_if.sv */
// handshake channels of the smoother: points in, smoothed points out, register writes

interface rgps_pt_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rgps_pkg::POS_W-1:0]     pos_x;
  logic signed [rgps_pkg::POS_W-1:0]     pos_y;

  modport source (output valid, pos_x, pos_y, input ready);
  modport sink   (input valid, pos_x, pos_y, output ready);
endinterface

interface rgps_pt_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [rgps_pkg::POS_W-1:0]     smooth_x;
  logic signed [rgps_pkg::POS_W-1:0]     smooth_y;

  modport source (output valid, smooth_x, smooth_y, input ready);
  modport sink   (input valid, smooth_x, smooth_y, output ready);
endinterface

interface rgps_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [rgps_pkg::CFG_IDX_W-1:0]        reg_index;
  logic [rgps_pkg::CFG_DATA_W-1:0]       wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

/* hdl/radius_gated_position_smoother_unit.sv */
// a point's word is written in ST_WRITE, then its n = 1..512 stored points are walked and drained
// a point is taken only in ST_IDLE, after the last walk; the single ring read port walks one entry a cycle
// the walk runs through a four stage read, square, gate and blend pipeline
// the finished result sits in an output register, so the next point is taken while it waits
// reset (rst_ni low, asynchronous) empties the history and loads the register reset values
// ring contents are not cleared; only entries written since reset are ever read
module radius_gated_position_smoother_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  rgps_pt_in_if.sink           pt_in,
  rgps_pt_out_if.source        pt_out,
  rgps_cfg_if.sink             cfg_wr
);

  localparam int AW = rgps_pkg::RING_AW;
  localparam int CW = rgps_pkg::CNT_W;
  localparam int PW = rgps_pkg::POS_W;
  localparam logic [16:0] DIV3_RECIP = 17'd43691;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRITE = 5'b00010,
    ST_WALK  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // ring index plus offset, wrapped at the ring depth
  function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(rgps_pkg::RING_DEPTH)) begin
      s = s - (CW+1)'(rgps_pkg::RING_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // signed divide by three, truncating toward zero, for magnitudes up to 2^16
  function automatic logic signed [16:0] div3(input logic signed [16:0] a);
    logic [16:0] mag;
    logic [33:0] prod;
    logic [16:0] q;
    mag  = a[16] ? 17'(-a) : 17'(a);
    prod = mag * DIV3_RECIP;
    q    = prod[33:17];
    return a[16] ? -$signed(q) : $signed(q);
  endfunction

  state_e                          state_q, state_d;
  logic [rgps_pkg::RADIUS_W-1:0]   radius_q;
  logic [rgps_pkg::HLEN_W-1:0]     hlen_q;
  logic [AW-1:0]                   oldest_q;
  logic [CW-1:0]                   count_q;
  logic [CW-1:0]                   k_q;
  logic [AW-1:0]                   rd_ptr_q;
  logic [PW-1:0]                   nx_q, ny_q;
  logic [31:0]                     r2_q;

  logic                            rd_vld_q, rd_last_q;
  logic                            s1_vld_q, s1_last_q;
  logic [31:0]                     s1_sqx_q, s1_sqy_q;
  logic [PW-1:0]                   s1_px_q, s1_py_q;
  logic                            s2_vld_q, s2_last_q, s2_hit_q;
  logic [PW-1:0]                   s2_px_q, s2_py_q;
  logic signed [16:0]              s2_px3_q, s2_py3_q;
  logic [PW-1:0]                   vx_q, vy_q;
  logic                            out_vld_q;
  logic [PW-1:0]                   out_x_q, out_y_q;

  logic                            accept;
  logic                            out_free;
  logic                            issue;
  logic                            walk_last;
  logic [CW-1:0]                   limit;
  logic [CW-1:0]                   trim_cnt;
  logic [AW-1:0]                   trim_old;
  logic [AW-1:0]                   wr_addr;
  logic                            ram_we;
  logic [rgps_pkg::ENTRY_W-1:0]    ram_rdata;
  logic [PW-1:0]                   rd_px, rd_py;
  logic signed [16:0]              dx, dy;
  logic signed [33:0]              dx_sq, dy_sq;
  logic [32:0]                     d2;
  logic                            v_zero;
  logic [PW-1:0]                   blend_x, blend_y;

  // handshakes
  assign pt_in.ready  = (state_q == ST_IDLE);
  assign accept       = pt_in.valid && pt_in.ready;
  assign cfg_wr.ready = 1'b1;
  assign out_free     = !out_vld_q || pt_out.ready;

  // trim of the history to the limit before the append
  always_comb begin
    if (32'(hlen_q) > 32'(rgps_pkg::RING_DEPTH - 1)) begin
      limit = CW'(rgps_pkg::RING_DEPTH - 1);
    end else begin
      limit = CW'(hlen_q);
    end
    if (count_q > limit) begin
      trim_cnt = limit;
      trim_old = ring_add(oldest_q, count_q - limit);
    end else begin
      trim_cnt = count_q;
      trim_old = oldest_q;
    end
  end

  // ring access: the append is written in ST_WRITE, ahead of the first walk read in ST_WALK, so no overlap
  assign wr_addr   = ring_add(oldest_q, count_q);
  assign ram_we    = (state_q == ST_WRITE);
  assign issue     = (state_q == ST_WALK);
  assign walk_last = (k_q == count_q - CW'(1));

  rgps_ram #(
    .WIDTH (rgps_pkg::ENTRY_W),
    .DEPTH (rgps_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_addr),
    .wdata_i ({ny_q, nx_q}),
    .re_i    (issue),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  // stage one: offsets to the newest point and their squares
  assign rd_px = ram_rdata[PW-1:0];
  assign rd_py = ram_rdata[2*PW-1:PW];
  assign dx    = {rd_px[PW-1], rd_px} - {nx_q[PW-1], nx_q};
  assign dy    = {rd_py[PW-1], rd_py} - {ny_q[PW-1], ny_q};
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  // stage two: distance gate
  assign d2 = {1'b0, s1_sqx_q} + {1'b0, s1_sqy_q};

  // stage three: blend into the running value
  assign v_zero  = (vx_q == '0) && (vy_q == '0);
  assign blend_x = PW'(div3($signed({vx_q, 1'b0})) + s2_px3_q);
  assign blend_y = PW'(div3($signed({vy_q, 1'b0})) + s2_py3_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_vld_q && s2_last_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      radius_q  <= rgps_pkg::GATE_RADIUS_RST;
      hlen_q    <= rgps_pkg::HISTORY_LEN_RST;
      oldest_q  <= '0;
      count_q   <= '0;
      k_q       <= '0;
      rd_ptr_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
      s2_vld_q  <= 1'b0;
      s2_last_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // register writes
      if (cfg_wr.valid) begin
        case (cfg_wr.reg_index)
          rgps_pkg::REG_GATE_RADIUS: radius_q <= cfg_wr.wdata[rgps_pkg::RADIUS_W-1:0];
          rgps_pkg::REG_HISTORY_LEN: hlen_q   <= cfg_wr.wdata[rgps_pkg::HLEN_W-1:0];
          default: ;
        endcase
      end

      // history bookkeeping
      if (accept) begin
        oldest_q <= trim_old;
        count_q  <= trim_cnt;
      end
      if (state_q == ST_WRITE) begin
        count_q  <= count_q + CW'(1);
        k_q      <= '0;
        rd_ptr_q <= oldest_q;
      end
      if (issue) begin
        k_q      <= k_q + CW'(1);
        rd_ptr_q <= ring_add(rd_ptr_q, CW'(1));
      end

      // walk pipeline valids
      rd_vld_q  <= issue;
      rd_last_q <= issue && walk_last;
      s1_vld_q  <= rd_vld_q;
      s1_last_q <= rd_last_q;
      s2_vld_q  <= s1_vld_q;
      s2_last_q <= s1_last_q;

      // result word
      if ((state_q == ST_DONE) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (pt_out.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      nx_q <= pt_in.pos_x;
      ny_q <= pt_in.pos_y;
    end

    s1_sqx_q <= dx_sq[31:0];
    s1_sqy_q <= dy_sq[31:0];
    s1_px_q  <= rd_px;
    s1_py_q  <= rd_py;

    s2_hit_q <= (d2 < {1'b0, r2_q});
    s2_px_q  <= s1_px_q;
    s2_py_q  <= s1_py_q;
    s2_px3_q <= div3($signed({s1_px_q[PW-1], s1_px_q}));
    s2_py3_q <= div3($signed({s1_py_q[PW-1], s1_py_q}));

    // running value: cleared per point, loaded or blended on each gated entry
    if (state_q == ST_WRITE) begin
      r2_q <= 32'(radius_q) * 32'(radius_q);
      vx_q <= '0;
      vy_q <= '0;
    end else if (s2_vld_q && s2_hit_q) begin
      if (v_zero) begin
        vx_q <= s2_px_q;
        vy_q <= s2_py_q;
      end else begin
        vx_q <= blend_x;
        vy_q <= blend_y;
      end
    end

    if ((state_q == ST_DONE) && out_free) begin
      out_x_q <= vx_q;
      out_y_q <= vy_q;
    end
  end

  assign pt_out.valid    = out_vld_q;
  assign pt_out.smooth_x = out_x_q;
  assign pt_out.smooth_y = out_y_q;

endmodule

/* hdl/rgps_ram.sv */
// generic simple dual port ram with registered read
module rgps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered and enabled by re_i
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rgps_checker.sv */
// port level checks of the smoother and their bind to the top level
`include "radius_gated_position_smoother_unit_defines.svh"

module rgps_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [rgps_pkg::POS_W-1:0] out_x_i,
  input logic [rgps_pkg::POS_W-1:0] out_y_i
);

  // a taken point keeps the input closed while its word is written and walked
  `RGPS_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)
  `RGPS_ASSERT_NOW(a_busy_during_walk, in_valid_i && in_ready_i, ##2 !in_ready_i)

  // no result word can appear in the cycle after a point is taken
  `RGPS_ASSERT_NEXT(a_no_early_result, in_valid_i && in_ready_i && !out_valid_i, !out_valid_i)

  // a stalled result word stays and holds its value
  `RGPS_ASSERT_NEXT(a_result_held, out_valid_i && !out_ready_i,
                    out_valid_i && $stable(out_x_i) && $stable(out_y_i))

endmodule

bind radius_gated_position_smoother_unit rgps_checker u_rgps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (pt_in.valid),
  .in_ready_i  (pt_in.ready),
  .out_valid_i (pt_out.valid),
  .out_ready_i (pt_out.ready),
  .out_x_i     (pt_out.smooth_x),
  .out_y_i     (pt_out.smooth_y)
);

/* test/testbench.sv */
// testbench of the radius gated position smoother: directed and random points checked against a predictor
`timescale 1ns / 1ps

module testbench;

  localparam int POS_W      = rgps_pkg::POS_W;
  localparam int ENTRY_W    = rgps_pkg::ENTRY_W;
  localparam int RING_DEPTH = rgps_pkg::RING_DEPTH;
  localparam int RADIUS_W   = rgps_pkg::RADIUS_W;
  localparam int HLEN_W     = rgps_pkg::HLEN_W;
  localparam int CFG_IDX_W  = rgps_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = rgps_pkg::CFG_DATA_W;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int ITEM_TARGET = 1160;
  localparam int IDLE_PCT    = 33;
  localparam int PAUSE_EVERY = 97;

  // register indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } point_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // locally owned drive values, all known from time zero
  logic                    in_valid_q  = 1'b0;
  logic signed [POS_W-1:0] in_x_q      = '0;
  logic signed [POS_W-1:0] in_y_q      = '0;
  logic                    out_ready_q = 1'b0;
  logic                    cfg_valid_q = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_q   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_q  = '0;

  logic in_taken    = 1'b0;
  logic drain_pause = 1'b0;
  int   idle_pct    = IDLE_PCT;

  point_t pending_pts[$];
  point_t expected_smooth[$];

  int error_count    = 0;
  int cycle_count    = 0;
  int accepted_count = 0;
  int items_queued   = 0;

  // predictor state: history ring, its window and the two registers
  logic [ENTRY_W-1:0]  hist_ring [RING_DEPTH];
  int                  hist_oldest   = 0;
  int                  hist_count    = 0;
  logic [RADIUS_W-1:0] gate_radius_q = rgps_pkg::GATE_RADIUS_RST;
  logic [HLEN_W-1:0]   hist_len_q    = rgps_pkg::HISTORY_LEN_RST;

  rgps_pt_in_if  pt_in_bus ();
  rgps_pt_out_if pt_out_bus ();
  rgps_cfg_if    cfg_bus ();

  assign pt_in_bus.valid    = in_valid_q;
  assign pt_in_bus.pos_x    = in_x_q;
  assign pt_in_bus.pos_y    = in_y_q;
  assign pt_out_bus.ready   = out_ready_q;
  assign cfg_bus.valid      = cfg_valid_q;
  assign cfg_bus.reg_index  = cfg_idx_q;
  assign cfg_bus.wdata      = cfg_data_q;

  radius_gated_position_smoother_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pt_in  (pt_in_bus),
    .pt_out (pt_out_bus),
    .cfg_wr (cfg_bus)
  );

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // trim, append, then walk the history oldest first with the radius gate
  function automatic point_t smooth_next(input logic signed [POS_W-1:0] nx,
                                         input logic signed [POS_W-1:0] ny);
    longint      r2, d2, dx, dy;
    int          vx, vy, px, py, k;
    logic [ENTRY_W-1:0] e;
    point_t      res;
    while (hist_count > 0 && hist_count > int'(hist_len_q)) begin
      hist_oldest = (hist_oldest + 1) % RING_DEPTH;
      hist_count--;
    end
    hist_ring[(hist_oldest + hist_count) % RING_DEPTH] = {ny, nx};
    hist_count++;
    r2 = longint'(gate_radius_q) * longint'(gate_radius_q);
    vx = 0;
    vy = 0;
    for (k = 0; k < hist_count; k++) begin
      e  = hist_ring[(hist_oldest + k) % RING_DEPTH];
      px = $signed(e[POS_W-1:0]);
      py = $signed(e[ENTRY_W-1:POS_W]);
      dx = longint'(px) - longint'(nx);
      dy = longint'(py) - longint'(ny);
      d2 = dx * dx + dy * dy;
      if (d2 < r2) begin
        // a zero running value reloads from the point
        if (vx != 0 || vy != 0) begin
          vx = vx * 2 / 3 + px / 3;
          vy = vy * 2 / 3 + py / 3;
        end else begin
          vx = px;
          vy = py;
        end
      end
    end
    res.x = vx[POS_W-1:0];
    res.y = vy[POS_W-1:0];
    return res;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0]  idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      rgps_pkg::REG_GATE_RADIUS: gate_radius_q = data[RADIUS_W-1:0];
      rgps_pkg::REG_HISTORY_LEN: hist_len_q = data[HLEN_W-1:0];
      default: ;
    endcase
  endfunction

  // result check, point acceptance and register writes at the rising edge
  always @(posedge clk_i) begin : sample_proc
    point_t want;
    point_t next_pt;
    if (rst_ni) begin
      if (pt_out_bus.valid && pt_out_bus.ready) begin
        if (expected_smooth.size() == 0) begin
          $error("smoothed word with no point outstanding: smooth_x %0d smooth_y %0d",
                 pt_out_bus.smooth_x, pt_out_bus.smooth_y);
          error_count++;
        end else begin
          want = expected_smooth[0];
          expected_smooth.delete(0);
          if (pt_out_bus.smooth_x !== want.x) begin
            $error("smooth_x expected %0d actual %0d", want.x, pt_out_bus.smooth_x);
            error_count++;
          end
          if (pt_out_bus.smooth_y !== want.y) begin
            $error("smooth_y expected %0d actual %0d", want.y, pt_out_bus.smooth_y);
            error_count++;
          end
        end
      end
      in_taken <= pt_in_bus.valid && pt_in_bus.ready;
      if (pt_in_bus.valid && pt_in_bus.ready) begin
        next_pt = smooth_next(pt_in_bus.pos_x, pt_in_bus.pos_y);
        expected_smooth = {expected_smooth, next_pt};
        pending_pts.delete(0);
        accepted_count <= accepted_count + 1;
      end
      if (cfg_bus.valid && cfg_bus.ready)
        apply_reg(cfg_bus.reg_index, cfg_bus.wdata);
    end
  end

  // point driver: front of the pending queue stays put until accepted
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || in_taken) begin
      if (drain_pause) begin
        in_valid_q <= 1'b0;
        if (expected_smooth.size() == 0)
          drain_pause <= 1'b0;
      end else if (in_taken && accepted_count % PAUSE_EVERY == 0) begin
        // hold off until every smoothed word is back
        in_valid_q  <= 1'b0;
        drain_pause <= 1'b1;
      end else if (pending_pts.size() != 0 && $urandom_range(99) >= idle_pct) begin
        in_valid_q <= 1'b1;
        in_x_q     <= pending_pts[0].x;
        in_y_q     <= pending_pts[0].y;
      end else begin
        in_valid_q <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    out_ready_q <= ($urandom_range(99) >= idle_pct);
  end

  // run time guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int clamp_pos(input int v);
    if (v > 32767)
      return 32767;
    if (v < -32768)
      return -32768;
    return v;
  endfunction

  task automatic queue_point(input int x, input int y);
    point_t p;
    p.x = POS_W'(x);
    p.y = POS_W'(y);
    pending_pts = {pending_pts, p};
    items_queued++;
  endtask

  // a drifting track with jitter, plus some full range noise
  task automatic queue_track(input int n, input int spread);
    int cx, cy, k, drift;
    cx    = int'($urandom_range(40000)) - 20000;
    cy    = int'($urandom_range(40000)) - 20000;
    drift = spread / 4 + 1;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < 15) begin
        queue_point(int'($urandom()), int'($urandom()));
      end else begin
        cx = clamp_pos(cx + int'($urandom_range(2 * drift)) - drift);
        cy = clamp_pos(cy + int'($urandom_range(2 * drift)) - drift);
        queue_point(clamp_pos(cx + int'($urandom_range(2 * spread)) - spread),
                    clamp_pos(cy + int'($urandom_range(2 * spread)) - spread));
      end
    end
  endtask

  // wait until every queued point is in and every smoothed word is back
  task automatic settle();
    do
      @(negedge clk_i);
    while (pending_pts.size() != 0 || expected_smooth.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_q <= 1'b1;
    cfg_idx_q   <= idx;
    cfg_data_q  <= data;
    do
      @(posedge clk_i);
    while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_valid_q <= 1'b0;
  endtask

  initial begin : stimulus
    int spread, radius, hlen;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed points at the reset settings
    queue_point(0, 0);
    queue_point(600, 800);        // origin exactly on the radius
    queue_point(600, 799);
    queue_point(1, 1);            // repeated unit points pull the running value down
    queue_point(1, 1);
    queue_point(1, 1);
    queue_point(-5, -7);          // truncation of negative values
    queue_point(-4, -8);
    queue_point(-6, -6);
    queue_point(32767, 32767);
    queue_point(32767, 32766);
    queue_point(-32768, -32768);
    queue_point(-32768, 32767);
    queue_point(32767, -32768);
    queue_point(-1, -1);
    queue_point(100, 100);
    queue_point(100, 1100);
    queue_point(100, 1099);
    queue_point(1100, 100);
    queue_point(-900, -1000);
    settle();

    // zero radius: nothing passes the gate
    write_reg(rgps_pkg::REG_GATE_RADIUS, '0);
    queue_track(8, 300);
    settle();

    // zero history length with the widest radius
    write_reg(rgps_pkg::REG_GATE_RADIUS, '1);
    write_reg(rgps_pkg::REG_HISTORY_LEN, '0);
    queue_track(16, 32767);
    settle();

    write_reg(rgps_pkg::REG_HISTORY_LEN, CFG_DATA_W'(1));
    write_reg(rgps_pkg::REG_GATE_RADIUS, CFG_DATA_W'(3000));
    queue_track(16, 2000);
    settle();

    // writes to indexes with no register behind them
    write_reg(REG_SPARE_2, CFG_DATA_W'($urandom()));
    write_reg(REG_SPARE_3, CFG_DATA_W'($urandom()));
    queue_track(8, 2000);
    settle();

    // longest history, upper data bits set, enough points to fill the ring
    write_reg(rgps_pkg::REG_GATE_RADIUS, CFG_DATA_W'(1500));
    write_reg(rgps_pkg::REG_HISTORY_LEN, {7'h7F, 9'd511});
    queue_track(530, 1000);
    settle();

    // stretch with no idling on either side
    idle_pct = 0;
    write_reg(rgps_pkg::REG_HISTORY_LEN, CFG_DATA_W'($urandom_range(1, 40)));
    write_reg(rgps_pkg::REG_GATE_RADIUS, CFG_DATA_W'($urandom_range(200, 4000)));
    queue_track(150, 800);
    settle();
    idle_pct = IDLE_PCT;

    // random settings, mostly short histories
    while (items_queued < ITEM_TARGET) begin
      case ($urandom_range(9))
        0:       radius = 0;
        1:       radius = 65535;
        2:       radius = int'($urandom_range(65535));
        default: radius = int'($urandom_range(1, 5000));
      endcase
      case ($urandom_range(19))
        0, 1:    hlen = 0;
        2:       hlen = 511;
        default: hlen = int'($urandom_range(1, 64));
      endcase
      case ($urandom_range(3))
        0:       spread = 4;
        1:       spread = 60;
        2:       spread = 600;
        default: spread = 4000;
      endcase
      write_reg(rgps_pkg::REG_GATE_RADIUS, CFG_DATA_W'(radius));
      write_reg(rgps_pkg::REG_HISTORY_LEN, {7'($urandom()), 9'(hlen)});
      queue_track(40, spread);
      settle();
    end

    // let any stray word show up
    repeat (RING_DEPTH + 16) @(posedge clk_i);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
